FILE: hdl/osdr_pkg.sv
package osdr_pkg;

   // Field and register widths
   localparam int COL_W  = 8;
   localparam int ROW_W  = 8;
   localparam int CHAR_W = 8;
   localparam int CC_W   = 8;   // column_count
   localparam int SS_W   = 10;  // screen_size
   localparam int CSR_W  = 10;

   localparam logic [CHAR_W-1:0] SPACE_CODE  = 8'h20;
   localparam logic [CHAR_W-1:0] SHADOW_INIT = 8'h02;

   localparam logic [CC_W-1:0] COLUMN_COUNT_RST = 8'd30;
   localparam logic [SS_W-1:0] SCREEN_SIZE_RST  = 10'd480;

   // Register indexes on the csr port
   typedef enum logic {
      CSR_COLUMN_COUNT = 1'b0,
      CSR_SCREEN_SIZE  = 1'b1
   } csr_idx_type;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_WRITE      = 2'd0,
      REQ_WRITE_CLIP = 2'd1,
      REQ_CLEAR      = 2'd2,
      REQ_REFRESH    = 2'd3
   } req_kind_type;

   // Microcode
   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] upc_type;

   typedef enum logic [3:0] {
      OP_INIT,       // reset sweep of both stores
      OP_IDLE,       // wait for a request, dispatch on its kind
      OP_WRITE,      // one character into the screen store
      OP_CLEAR,      // sweep screen store with spaces
      OP_DIV_INIT,   // load divider with the scan pointer
      OP_DIV_STEP,   // one quotient bit per cycle
      OP_DIV_DONE,   // load column/row tracker
      OP_WAIT_RD,    // store read latency
      OP_CMP,        // compare, update shadow, advance pointer
      OP_FIN         // flush the held result or the empty result
   } op_type;

   typedef enum logic [1:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_SCAN_MORE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } uword_type;

   localparam upc_type UA_INIT     = 4'd0;
   localparam upc_type UA_IDLE     = 4'd1;
   localparam upc_type UA_WRITE    = 4'd2;
   localparam upc_type UA_CLEAR    = 4'd3;
   localparam upc_type UA_REFRESH  = 4'd4;
   localparam upc_type UA_DIV_STEP = 4'd5;
   localparam upc_type UA_DIV_DONE = 4'd6;
   localparam upc_type UA_WAIT_RD  = 4'd7;
   localparam upc_type UA_CMP      = 4'd8;
   localparam upc_type UA_FIN      = 4'd9;

   function automatic uword_type ucode_rom(input upc_type pc);
      uword_type w;
      case (pc)
         UA_INIT:     w = '{op: OP_INIT,     cond: COND_ALWAYS,    target: UA_IDLE};
         UA_IDLE:     w = '{op: OP_IDLE,     cond: COND_NEVER,     target: UA_IDLE};
         UA_WRITE:    w = '{op: OP_WRITE,    cond: COND_ALWAYS,    target: UA_IDLE};
         UA_CLEAR:    w = '{op: OP_CLEAR,    cond: COND_ALWAYS,    target: UA_IDLE};
         UA_REFRESH:  w = '{op: OP_DIV_INIT, cond: COND_NEVER,     target: UA_IDLE};
         UA_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_NEVER,     target: UA_IDLE};
         UA_DIV_DONE: w = '{op: OP_DIV_DONE, cond: COND_ALWAYS,    target: UA_CMP};
         UA_WAIT_RD:  w = '{op: OP_WAIT_RD,  cond: COND_NEVER,     target: UA_IDLE};
         UA_CMP:      w = '{op: OP_CMP,      cond: COND_SCAN_MORE, target: UA_WAIT_RD};
         UA_FIN:      w = '{op: OP_FIN,      cond: COND_ALWAYS,    target: UA_IDLE};
         default:     w = '{op: OP_IDLE,     cond: COND_NEVER,     target: UA_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: hdl/osdr_ram.sv
module osdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/osd_dirty_char_refresh_core.sv
// Character screen store with a shadow copy for incremental OSD refresh.
//
// req channel: req_tuser carries the request kind (write, clipped write,
// clear, refresh); req_tdata carries column, row and character of a write.
// rsp channel: one item per changed position found by a refresh, carrying
// column, row and new character; rsp_tlast marks the final item of a
// refresh. A refresh that finds nothing sends one item with rsp_tuser set.
// csr port: column_count (index 0) and screen_size (index 1), written
// while the block is idle (a rule for the user; the block does not enforce it).
//
// Sequence (a microcoded sequencer steps through a small control ROM):
//   write   : dispatch, then the store write
//   clear   : dispatch, then a sweep of one store entry per cycle
//   refresh : dispatch and divider load; the scan pointer is split into
//             column/row (restoring divider, one bit/cycle), the tracker is
//             loaded, then the first position is compared and each further
//             one after a store read wait, up to CHARS_PER_REFRESH, then finish.
// Each found item is held back until the next change or the finish so that
// tlast can be set on it; a further change found with the output stalled holds
// the scan. Reset fills all entries (spaces / 0x02 shadow), req_tready held low.
module osd_dirty_char_refresh_core #(
   parameter int SCREEN_CHARS      = 512,
   parameter int CHARS_PER_REFRESH = 20
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // col[7:0], row[15:8], char_code[23:16]
   input  logic [1:0]  req_tuser,   // req_type[1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_col[7:0], out_row[15:8], out_char[23:16]
   output logic [0:0]  rsp_tuser,   // empty_res[0]
   output logic        rsp_tlast,   // last

   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [9:0]  csr_wdata
);

   localparam int AW  = $clog2(SCREEN_CHARS);
   localparam int DCW = $clog2(AW);
   localparam int CW  = $clog2(CHARS_PER_REFRESH + 1);
   // common width for pointer vs. scan limit compare
   localparam int XW  = (AW + 1 > osdr_pkg::SS_W) ? AW + 1 : osdr_pkg::SS_W;

   // ---------------- registers ----------------
   osdr_pkg::upc_type pc_ff, pc_in;
   logic [AW-1:0]  ptr_ff, ptr_in;        // sweep address
   logic [AW-1:0]  pos_ff, pos_in;        // rotating scan pointer
   logic [CW-1:0]  cnt_ff, cnt_in;        // positions scanned this refresh
   logic [7:0]     trk_col_ff, trk_col_in;
   logic [7:0]     trk_row_ff, trk_row_in;
   logic [7:0]     rem_ff, rem_in;
   logic [AW-1:0]  quo_ff, quo_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;

   logic [7:0] wr_col_ff, wr_col_in;
   logic [7:0] wr_row_ff, wr_row_in;
   logic [7:0] wr_char_ff, wr_char_in;
   logic       wr_clip_ff, wr_clip_in;

   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_col_ff, pend_col_in;
   logic [7:0] pend_row_ff, pend_row_in;
   logic [7:0] pend_char_ff, pend_char_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_col_ff, rsp_col_in;
   logic [7:0] rsp_row_ff, rsp_row_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_empty_ff, rsp_empty_in;
   logic       rsp_last_ff, rsp_last_in;

   logic [osdr_pkg::CC_W-1:0] column_count_ff, column_count_in;
   logic [osdr_pkg::SS_W-1:0] screen_size_ff, screen_size_in;

   // ---------------- store ports ----------------
   logic          scr_we;
   logic [AW-1:0] scr_waddr;
   logic [7:0]    scr_wdata;
   logic [7:0]    scr_rdata;
   logic          shd_we;
   logic [AW-1:0] shd_waddr;
   logic [7:0]    shd_wdata;
   logic [7:0]    shd_rdata;

   // Both stores are read at the scan pointer on every cycle.
   osdr_ram #(.WIDTH(8), .DEPTH(SCREEN_CHARS)) u_screen (
      .clock   (clock),
      .wr_en   (scr_we),
      .wr_addr (scr_waddr),
      .wr_data (scr_wdata),
      .rd_addr (pos_ff),
      .rd_data (scr_rdata)
   );

   osdr_ram #(.WIDTH(8), .DEPTH(SCREEN_CHARS)) u_shadow (
      .clock   (clock),
      .wr_en   (shd_we),
      .wr_addr (shd_waddr),
      .wr_data (shd_wdata),
      .rd_addr (pos_ff),
      .rd_data (shd_rdata)
   );

   // ---------------- datapath and sequencer ----------------
   osdr_pkg::uword_type uw;
   logic          hold;
   logic          accept;
   logic          out_free;
   logic [7:0]    cols;
   logic [XW-1:0] lim;
   logic [XW-1:0] next_x;
   logic          wrap;
   logic          scan_end;
   logic          ptr_last;
   logic          diff;
   logic [15:0]   prod;
   logic [16:0]   waddr_full;
   logic          drop;
   logic [8:0]    trial;
   logic          ge;

   assign req_tready = (uw.op == osdr_pkg::OP_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      uw       = osdr_pkg::ucode_rom(pc_ff);
      out_free = !rsp_valid_ff || rsp_tready;
      cols     = (column_count_ff == '0) ? 8'd1 : column_count_ff;

      // scan limit: screen_size, zero acting as one, saturated to store depth
      if (screen_size_ff == '0) begin
         lim = XW'(1);
      end else if (XW'(screen_size_ff) > XW'(SCREEN_CHARS)) begin
         lim = XW'(SCREEN_CHARS);
      end else begin
         lim = XW'(screen_size_ff);
      end
      next_x   = XW'(pos_ff) + XW'(1);
      wrap     = (next_x >= lim);
      scan_end = wrap || (cnt_ff == CW'(CHARS_PER_REFRESH - 1));
      ptr_last = (ptr_ff == AW'(SCREEN_CHARS - 1));
      diff     = (scr_rdata != shd_rdata);

      prod       = 16'(wr_row_ff) * 16'(cols);
      waddr_full = 17'(prod) + 17'(wr_col_ff);
      drop       = (wr_clip_ff && (wr_col_ff >= cols)) ||
                   (waddr_full >= 17'(SCREEN_CHARS));

      trial = {rem_ff, quo_ff[AW-1]};
      ge    = (trial >= {1'b0, cols});

      // defaults: hold everything
      hold          = 1'b0;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      trk_col_in    = trk_col_ff;
      trk_row_in    = trk_row_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      wr_col_in     = wr_col_ff;
      wr_row_in     = wr_row_ff;
      wr_char_in    = wr_char_ff;
      wr_clip_in    = wr_clip_ff;
      pend_valid_in = pend_valid_ff;
      pend_col_in   = pend_col_ff;
      pend_row_in   = pend_row_ff;
      pend_char_in  = pend_char_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;
      scr_we        = 1'b0;
      scr_waddr     = ptr_ff;
      scr_wdata     = osdr_pkg::SPACE_CODE;
      shd_we        = 1'b0;
      shd_waddr     = ptr_ff;
      shd_wdata     = osdr_pkg::SHADOW_INIT;

      case (uw.op)
         osdr_pkg::OP_INIT: begin
            scr_we = 1'b1;
            shd_we = 1'b1;
            hold   = !ptr_last;
            ptr_in = ptr_last ? '0 : ptr_ff + AW'(1);
         end
         osdr_pkg::OP_IDLE: begin
            hold = !accept;
            if (accept) begin
               wr_col_in  = req_tdata[7:0];
               wr_row_in  = req_tdata[15:8];
               wr_char_in = req_tdata[23:16];
               wr_clip_in = (req_tuser == osdr_pkg::REQ_WRITE_CLIP);
            end
         end
         osdr_pkg::OP_WRITE: begin
            scr_we    = !drop;
            scr_waddr = waddr_full[AW-1:0];
            scr_wdata = wr_char_ff;
         end
         osdr_pkg::OP_CLEAR: begin
            scr_we = 1'b1;
            hold   = !ptr_last;
            ptr_in = ptr_last ? '0 : ptr_ff + AW'(1);
         end
         osdr_pkg::OP_DIV_INIT: begin
            rem_in        = '0;
            quo_in        = pos_ff;
            div_cnt_in    = '0;
            cnt_in        = '0;
            pend_valid_in = 1'b0;
         end
         osdr_pkg::OP_DIV_STEP: begin
            rem_in     = ge ? 8'(trial - {1'b0, cols}) : trial[7:0];
            quo_in     = {quo_ff[AW-2:0], ge};
            div_cnt_in = div_cnt_ff + DCW'(1);
            hold       = (div_cnt_ff != DCW'(AW - 1));
         end
         osdr_pkg::OP_DIV_DONE: begin
            trk_col_in = rem_ff;
            trk_row_in = 8'(quo_ff);
         end
         osdr_pkg::OP_WAIT_RD: begin
         end
         osdr_pkg::OP_CMP: begin
            // a second change while the output is still full must wait
            hold = diff && pend_valid_ff && !out_free;
            if (!hold) begin
               if (diff) begin
                  shd_we    = 1'b1;
                  shd_waddr = pos_ff;
                  shd_wdata = scr_rdata;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_col_in   = pend_col_ff;
                     rsp_row_in   = pend_row_ff;
                     rsp_char_in  = pend_char_ff;
                     rsp_empty_in = 1'b0;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_col_in   = trk_col_ff;
                  pend_row_in   = trk_row_ff;
                  pend_char_in  = scr_rdata;
               end
               cnt_in = cnt_ff + CW'(1);
               if (wrap) begin
                  pos_in     = '0;
                  trk_col_in = '0;
                  trk_row_in = '0;
               end else begin
                  pos_in = next_x[AW-1:0];
                  if (trk_col_ff + 8'd1 == cols) begin
                     trk_col_in = '0;
                     trk_row_in = trk_row_ff + 8'd1;
                  end else begin
                     trk_col_in = trk_col_ff + 8'd1;
                  end
               end
            end
         end
         osdr_pkg::OP_FIN: begin
            hold = !out_free;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = !pend_valid_ff;
               rsp_col_in    = pend_valid_ff ? pend_col_ff  : 8'd0;
               rsp_row_in    = pend_valid_ff ? pend_row_ff  : 8'd0;
               rsp_char_in   = pend_valid_ff ? pend_char_ff : 8'd0;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // next step
      if (hold) begin
         pc_in = pc_ff;
      end else if (uw.op == osdr_pkg::OP_IDLE) begin
         case (osdr_pkg::req_kind_type'(req_tuser))
            osdr_pkg::REQ_WRITE,
            osdr_pkg::REQ_WRITE_CLIP: pc_in = osdr_pkg::UA_WRITE;
            osdr_pkg::REQ_CLEAR:      pc_in = osdr_pkg::UA_CLEAR;
            osdr_pkg::REQ_REFRESH:    pc_in = osdr_pkg::UA_REFRESH;
            default:                  pc_in = osdr_pkg::UA_IDLE;
         endcase
      end else begin
         case (uw.cond)
            osdr_pkg::COND_ALWAYS:    pc_in = uw.target;
            osdr_pkg::COND_SCAN_MORE: pc_in = scan_end ? pc_ff + osdr_pkg::PC_W'(1)
                                                       : uw.target;
            default:                  pc_in = pc_ff + osdr_pkg::PC_W'(1);
         endcase
      end

      // configuration
      column_count_in = column_count_ff;
      screen_size_in  = screen_size_ff;
      if (csr_we) begin
         case (osdr_pkg::csr_idx_type'(csr_addr))
            osdr_pkg::CSR_COLUMN_COUNT: column_count_in = csr_wdata[7:0];
            osdr_pkg::CSR_SCREEN_SIZE:  screen_size_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff           <= osdr_pkg::UA_INIT;
         ptr_ff          <= '0;
         pos_ff          <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         column_count_ff <= osdr_pkg::COLUMN_COUNT_RST;
         screen_size_ff  <= osdr_pkg::SCREEN_SIZE_RST;
      end else begin
         pc_ff           <= pc_in;
         ptr_ff          <= ptr_in;
         pos_ff          <= pos_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         column_count_ff <= column_count_in;
         screen_size_ff  <= screen_size_in;
      end
      cnt_ff       <= cnt_in;
      trk_col_ff   <= trk_col_in;
      trk_row_ff   <= trk_row_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_cnt_ff   <= div_cnt_in;
      wr_col_ff    <= wr_col_in;
      wr_row_ff    <= wr_row_in;
      wr_char_ff   <= wr_char_in;
      wr_clip_ff   <= wr_clip_in;
      pend_col_ff  <= pend_col_in;
      pend_row_ff  <= pend_row_in;
      pend_char_ff <= pend_char_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_char_ff, rsp_row_ff, rsp_col_ff};
   assign rsp_tuser  = rsp_empty_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/osdr_checker.sv
module osdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // stalled item stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // empty refresh result is a lone, zeroed, final item
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == 24'd0))
      else $error("empty result not last or not zero");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // writes and clears never produce items
   a_no_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != osdr_pkg::REQ_REFRESH) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("item produced by a write or clear");

endmodule

bind osd_dirty_char_refresh_core osdr_checker u_osdr_checker (.*);

FILE: dv/osd_dirty_char_refresh_core_tb.sv
`timescale 1ns / 1ps

module osd_dirty_char_refresh_core_tb;

   localparam int SCREEN_CHARS      = 512;
   localparam int CHARS_PER_REFRESH = 20;
   // Idle gap after the last report: covers a trailing clear sweep plus the
   // finishing step of a refresh.
   localparam int QUIET_CYCLES      = SCREEN_CHARS + 100;
   localparam int HOLD_CYCLES       = 400;         // long rsp back-pressure
   localparam int RUN_LIMIT_NS      = 20_000_000;

   typedef struct {
      osdr_pkg::req_kind_type kind;
      logic [7:0]             col;
      logic [7:0]             row;
      logic [7:0]             ch;
   } osd_req_type;

   // One report of a changed screen position (or the empty report)
   typedef struct {
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] ch;
      logic       empty;
      logic       last;
   } dirty_hit_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic        csr_addr   = 1'b0;
   logic [9:0]  csr_wdata  = '0;

   osd_dirty_char_refresh_core #(
      .SCREEN_CHARS      (SCREEN_CHARS),
      .CHARS_PER_REFRESH (CHARS_PER_REFRESH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Shadowed copy of the block: screen image, shadow image, scan pointer
   // and the two config registers.
   // ---------------------------------------------------------------------
   logic [7:0]  screen_img [SCREEN_CHARS];
   logic [7:0]  shadow_img [SCREEN_CHARS];
   int unsigned scan_ptr;
   logic [7:0]  cols_reg;
   logic [9:0]  size_reg;

   osd_req_type   req_q[$];      // items waiting for the driver
   dirty_hit_type dirty_q[$];    // reports still owed by the block
   int unsigned queued_cnt   = 0;
   int unsigned accepted_cnt = 0;
   int unsigned err_cnt      = 0;

   int unsigned snd_idle_pct  = 0;
   int unsigned rcv_stall_pct = 0;
   int unsigned hold_reqs     = 0;  // bumped to ask for one long stall
   int unsigned hold_seen     = 0;
   int unsigned hold_left     = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("osd_dirty_char_refresh_core_tb failed");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      err_cnt++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   // Update the image for one accepted item and queue the reports it owes.
   task automatic apply_request(input osdr_pkg::req_kind_type kind, input logic [7:0] c,
                                input logic [7:0] r, input logic [7:0] ch);
      int unsigned   cols;
      int unsigned   addr;
      int unsigned   lim;
      int unsigned   p;
      dirty_hit_type hit;
      dirty_hit_type batch[$];
      cols = (cols_reg == 0) ? 1 : cols_reg;   // zero column count acts as one
      case (kind)
         osdr_pkg::REQ_WRITE, osdr_pkg::REQ_WRITE_CLIP: begin
            // clipped kind drops anything past the end of the row
            if (kind == osdr_pkg::REQ_WRITE_CLIP && c >= cols) return;
            addr = r * cols + c;
            if (addr < SCREEN_CHARS) screen_img[addr] = ch;
         end
         osdr_pkg::REQ_CLEAR: begin
            foreach (screen_img[i]) screen_img[i] = osdr_pkg::SPACE_CODE;
         end
         default: begin
            // scan limit: screen_size, zero taken as one, saturated to store
            lim = (size_reg == 0) ? 1 :
                  ((size_reg > SCREEN_CHARS) ? SCREEN_CHARS : size_reg);
            for (int k = 0; k < CHARS_PER_REFRESH; k++) begin
               // a pointer left past a lowered limit still lands in the store
               p = scan_ptr % SCREEN_CHARS;
               if (screen_img[p] != shadow_img[p]) begin
                  shadow_img[p] = screen_img[p];
                  hit.col   = 8'(p % cols);
                  hit.row   = 8'(p / cols);
                  hit.ch    = screen_img[p];
                  hit.empty = 1'b0;
                  hit.last  = 1'b0;
                  batch.push_back(hit);
               end
               scan_ptr = p + 1;
               if (scan_ptr >= lim) begin
                  scan_ptr = 0;   // wrap ends the scan early
                  break;
               end
            end
            if (batch.size() == 0) begin
               hit = '{col: 8'h00, row: 8'h00, ch: 8'h00, empty: 1'b1, last: 1'b1};
               batch.push_back(hit);
            end else begin
               batch[batch.size()-1].last = 1'b1;
            end
            foreach (batch[i]) dirty_q.push_back(batch[i]);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Driver: next item goes out once the current one is taken (or none is
   // up). Sender gaps are drawn per cycle.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      osd_req_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            it = req_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= it.kind;
            req_tdata  <= {it.ch, it.row, it.col};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver ready: random stalls, plus a long hold when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
         hold_seen  <= hold_reqs;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each accepted request item, check each accepted
   // report item against the oldest one owed.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      dirty_hit_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_request(osdr_pkg::req_kind_type'(req_tuser), req_tdata[7:0],
                          req_tdata[15:8], req_tdata[23:16]);
            accepted_cnt++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (dirty_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected report col %0d row %0d char %02h",
                                       rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16]));
            end else begin
               want = dirty_q.pop_front();
               if (rsp_tdata[7:0] !== want.col || rsp_tdata[15:8] !== want.row ||
                   rsp_tdata[23:16] !== want.ch || rsp_tuser[0] !== want.empty ||
                   rsp_tlast !== want.last)
                  flag_mismatch($sformatf(
                     "got col %0d row %0d char %02h empty %0b last %0b, want %0d %0d %02h %0b %0b",
                     rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tuser[0],
                     rsp_tlast, want.col, want.row, want.ch, want.empty, want.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_item(input osdr_pkg::req_kind_type kind, input logic [7:0] c,
                            input logic [7:0] r, input logic [7:0] ch);
      osd_req_type it;
      it = '{kind: kind, col: c, row: r, ch: ch};
      req_q.push_back(it);
      queued_cnt++;
   endtask

   // Registers change only with the block idle; model follows right away.
   task automatic write_csr(input osdr_pkg::csr_idx_type idx, input logic [9:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == osdr_pkg::CSR_COLUMN_COUNT) cols_reg = val[7:0];
      else size_reg = val;
   endtask

   // Wait for every item to be taken and every report to arrive, then let
   // a possible clear sweep run out.
   task automatic wait_drain();
      while (accepted_cnt != queued_cnt || dirty_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Mostly writes aimed inside the scanned area mixed with refreshes, so
   // scans keep finding changes; some raw writes and clears as noise.
   task automatic queue_random(input int count);
      int unsigned cols;
      int unsigned lim;
      int unsigned addr;
      int unsigned sel;
      cols = (cols_reg == 0) ? 1 : cols_reg;
      lim  = (size_reg == 0) ? 1 :
             ((size_reg > SCREEN_CHARS) ? SCREEN_CHARS : size_reg);
      repeat (count) begin
         sel = $urandom_range(99);
         if (sel < 50) begin
            addr = $urandom_range(lim - 1);
            if (addr / cols > 255) addr = addr % (256 * cols);
            push_item(osdr_pkg::req_kind_type'($urandom_range(1)), 8'(addr % cols),
                      8'(addr / cols),
                      ($urandom_range(3) == 0) ? osdr_pkg::SPACE_CODE : 8'($urandom));
         end else if (sel < 62) begin
            push_item(osdr_pkg::req_kind_type'($urandom_range(1)), 8'($urandom),
                      8'($urandom), 8'($urandom));
         end else if (sel < 65) begin
            push_item(osdr_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            push_item(osdr_pkg::REQ_REFRESH, 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic run_phase(input logic [9:0] cc, input logic [9:0] ss,
                            input int unsigned snd, input int unsigned rcv,
                            input int count, input bit press);
      wait_drain();
      write_csr(osdr_pkg::CSR_COLUMN_COUNT, cc);
      write_csr(osdr_pkg::CSR_SCREEN_SIZE, ss);
      snd_idle_pct  = snd;
      rcv_stall_pct = rcv;
      if (press) hold_reqs++;
      queue_random(count);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      foreach (screen_img[i]) screen_img[i] = osdr_pkg::SPACE_CODE;
      foreach (shadow_img[i]) shadow_img[i] = osdr_pkg::SHADOW_INIT;
      scan_ptr = 0;
      cols_reg = osdr_pkg::COLUMN_COUNT_RST;
      size_reg = osdr_pkg::SCREEN_SIZE_RST;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset config (30 columns, 480 positions). Items queue up
      // while the block runs its clearing pass.
      push_item(osdr_pkg::REQ_WRITE,      8'd0,   8'd0,   8'h00);  // first position
      push_item(osdr_pkg::REQ_WRITE,      8'd29,  8'd15,  8'hFF);  // last scanned
      push_item(osdr_pkg::REQ_WRITE_CLIP, 8'd29,  8'd16,  8'h41);  // clipped, in range
      push_item(osdr_pkg::REQ_WRITE_CLIP, 8'd30,  8'd0,   8'h42);  // clipped off row
      push_item(osdr_pkg::REQ_WRITE,      8'd40,  8'd0,   8'h43);  // spills to next row
      push_item(osdr_pkg::REQ_WRITE,      8'd1,   8'd17,  8'h7E);  // top of store
      push_item(osdr_pkg::REQ_WRITE,      8'd2,   8'd17,  8'h55);  // just past store
      push_item(osdr_pkg::REQ_WRITE,      8'd255, 8'd255, 8'hAA);  // far outside
      push_item(osdr_pkg::REQ_WRITE_CLIP, 8'd0,   8'd255, 8'h80);  // clipped, outside
      push_item(osdr_pkg::REQ_REFRESH,    8'd0,   8'd0,   8'd0);
      push_item(osdr_pkg::REQ_REFRESH,    8'hFF,  8'hFF,  8'hFF);
      push_item(osdr_pkg::REQ_CLEAR,      8'd0,   8'd0,   8'd0);
      push_item(osdr_pkg::REQ_REFRESH,    8'd0,   8'd0,   8'd0);
      push_item(osdr_pkg::REQ_WRITE,      8'd5,   8'd0,   osdr_pkg::SPACE_CODE); // no change

      // Shrink the scan area below the pointer: next scan looks at one
      // position then wraps; later scans end early at 25, then run dry.
      wait_drain();
      write_csr(osdr_pkg::CSR_SCREEN_SIZE, 10'd25);
      repeat (5) push_item(osdr_pkg::REQ_REFRESH, 8'd0, 8'd0, 8'd0);

      // Random phases across settings and idle modes.
      run_phase(10'd1,    10'd512,  0,  0,  55, 1'b0);
      run_phase(10'd255,  10'd1023, 50, 0,  55, 1'b0);
      run_phase(10'h300,  10'd0,    0,  50, 50, 1'b0);  // zero count and size
      run_phase(10'd16,   10'd64,   25, 25, 55, 1'b0);
      run_phase(10'd30,   10'd480,  0,  50, 55, 1'b0);
      run_phase(10'd7,    10'd100,  0,  0,  40, 1'b1);  // long rsp hold

      wait_drain();
      if (err_cnt == 0) begin
         $display("osd_dirty_char_refresh_core_tb passed");
      end else begin
         $display("osd_dirty_char_refresh_core_tb failed");
      end
      $finish;
   end

endmodule
